// File: hw/rtl/vlrb_pkg.sv
package vlrb_pkg;

   // configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 41;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_HOST_FEATURES = 2'd0,
      CSR_QUEUE_COUNT   = 2'd1,
      CSR_GUEST_MEMORY  = 2'd2
   } csr_index_type;

   // request function
   typedef enum logic [1:0] {
      FUNC_READ  = 2'd0,
      FUNC_WRITE = 2'd1,
      FUNC_USED  = 2'd2
   } func_type;

   // legacy header offsets
   localparam logic [7:0] PORT_DEV_FEATURES  = 8'd0;
   localparam logic [7:0] PORT_DRV_FEATURES  = 8'd4;
   localparam logic [7:0] PORT_QUEUE_PFN     = 8'd8;
   localparam logic [7:0] PORT_QUEUE_SIZE    = 8'd12;
   localparam logic [7:0] PORT_QUEUE_SELECT  = 8'd14;
   localparam logic [7:0] PORT_QUEUE_NOTIFY  = 8'd16;
   localparam logic [7:0] PORT_DEVICE_STATUS = 8'd18;
   localparam logic [7:0] PORT_ISR_STATUS    = 8'd19;
   localparam logic [7:0] PORT_DEVICE_BASE   = 8'd20;

   typedef enum logic [2:0] {
      RC_OK          = 3'd0,
      RC_UNSUPPORTED = 3'd1,
      RC_BAD_SIZE    = 3'd2,
      RC_MISMATCH    = 3'd3,
      RC_RANGE       = 3'd4,
      RC_DEVICE      = 3'd5
   } rc_type;

   // access widths in bytes
   localparam logic [2:0] SIZE_NONE  = 3'd0;
   localparam logic [2:0] SIZE_BYTE  = 3'd1;
   localparam logic [2:0] SIZE_HALF  = 3'd2;
   localparam logic [2:0] SIZE_WORD  = 3'd4;

   // legacy ring layout
   localparam int PAGE_SHIFT   = 12;
   localparam int PAGE_MASK    = 4095;
   localparam int AVAIL_TAIL   = 6;
   localparam int USED_TAIL    = 6;
   localparam int RING_SPAN_W  = 21;
   localparam int RING_END_W   = 32 + PAGE_SHIFT + 1;

   typedef struct packed {
      logic [31:0] page;
      logic [15:0] entries;
   } row_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [7:0]  port;
      logic [2:0]  xfer_bytes;
      logic [31:0] write_data;
   } req_type;

endpackage

// File: hw/rtl/vlrb_ifs.sv
interface vlrb_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [7:0]  port;
   logic [2:0]  xfer_bytes;
   logic [31:0] write_data;

   modport source (output valid, func, port, xfer_bytes, write_data, input ready);
   modport sink (input valid, func, port, xfer_bytes, write_data, output ready);
endinterface

interface vlrb_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  result_code;
   logic [31:0] read_data;
   logic [2:0]  read_size;
   logic        notify_fire;
   logic [2:0]  notify_queue;
   logic        irq_pending;

   modport source (output valid, result_code, read_data, read_size, notify_fire,
                   notify_queue, irq_pending, input ready);
   modport sink (input valid, result_code, read_data, read_size, notify_fire,
                 notify_queue, irq_pending, output ready);
endinterface

interface vlrb_csr_if;
   logic                            valid;
   logic                            ready;
   logic [vlrb_pkg::CSR_INDEX_W-1:0] index;
   logic [vlrb_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/virtio_legacy_register_block.sv
// channel   dir  handshake        payload
// req_chan  in   valid / ready    func, port, xfer_bytes, write_data
// rsp_chan  out  valid / ready    result_code, read_data, read_size, notify_fire,
//                                 notify_queue, irq_pending
// csr_chan  in   valid / ready    index, data (always ready)
//
// Input stage, decode and state update, output register: one request per cycle
// sustained while the response side keeps accepting.
// Per-queue rows live in a RAM read at the selected queue; a forward register
// covers the row written by the previous request.
// Reset is synchronous; per-queue rows read as zero until written (valid bits).
// A stalled response holds the output register; req ready drops only when both
// stages are full.
module virtio_legacy_register_block #(
   parameter int MAX_QUEUES = 8
) (
   input  logic       clock,
   input  logic       reset,
   vlrb_req_if.sink   req_chan,
   vlrb_rsp_if.source rsp_chan,
   vlrb_csr_if.sink   csr_chan
);
   import vlrb_pkg::*;

   localparam int QW = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;
   localparam int LW = ($clog2(MAX_QUEUES + 1) > 4) ? $clog2(MAX_QUEUES + 1) : 4;
   localparam int RW = $bits(row_type);

   // configuration
   logic [31:0]           host_features_ff;
   logic [3:0]            queue_count_ff;
   logic [CSR_DATA_W-1:0] guest_memory_ff;

   // handshake state
   logic    s1_valid_ff, s1_valid_in;
   req_type s1_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    rsp_free, s1_go, req_fire;

   // block state
   logic [QW-1:0]         sel_ff, sel_in, sel_next;
   logic [7:0]            dev_status_ff, dev_status_next;
   logic                  isr_ff, isr_next;
   logic [MAX_QUEUES-1:0] row_valid_ff;
   logic                  fwd_ff;
   row_type               fwd_row_ff;
   row_type               ram_rd, cur_row, row_wdata;
   logic                  row_we, ram_we;

   // decode results
   rc_type      rc;
   logic [31:0] rdata;
   logic [2:0]  rsize;
   logic        fire;
   logic [2:0]  nq;

   // helpers
   logic [LW-1:0]          live;
   logic                   queue_ok, d16_ok;
   logic [15:0]            d16;
   logic [RING_SPAN_W-1:0] n_ext, desc_avail, used_off, ring_span;
   logic [RING_END_W-1:0]  ring_last;
   logic                   ring_fits;

   // response register
   logic [2:0]  rsp_rc_ff;
   logic [31:0] rsp_rdata_ff;
   logic [2:0]  rsp_rsize_ff;
   logic        rsp_fire_ff;
   logic [2:0]  rsp_nq_ff;
   logic        rsp_irq_ff;

   assign rsp_free        = !rsp_valid_ff || rsp_chan.ready;
   assign s1_go           = s1_valid_ff && rsp_free;
   assign req_chan.ready  = !s1_valid_ff || rsp_free;
   assign req_fire        = req_chan.valid && req_chan.ready;
   assign csr_chan.ready  = 1'b1;

   assign s1_valid_in  = req_fire ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s1_go ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         host_features_ff <= '0;
         queue_count_ff   <= 4'd1;
         guest_memory_ff  <= '0;
         sel_ff           <= '0;
         dev_status_ff    <= '0;
         isr_ff           <= 1'b0;
         row_valid_ff     <= '0;
         fwd_ff           <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         fwd_ff       <= ram_we;
         if (csr_chan.valid) begin
            unique case (csr_index_type'(csr_chan.index))
               CSR_HOST_FEATURES: host_features_ff <= csr_chan.data[31:0];
               CSR_QUEUE_COUNT:   queue_count_ff   <= csr_chan.data[3:0];
               CSR_GUEST_MEMORY:  guest_memory_ff  <= csr_chan.data;
               default: ;
            endcase
         end
         if (s1_go) begin
            sel_ff        <= sel_next;
            dev_status_ff <= dev_status_next;
            isr_ff        <= isr_next;
         end
         if (ram_we) begin
            row_valid_ff[sel_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_ff.func       <= req_chan.func;
         s1_ff.port       <= req_chan.port;
         s1_ff.xfer_bytes <= req_chan.xfer_bytes;
         s1_ff.write_data <= req_chan.write_data;
      end
      if (ram_we) begin
         fwd_row_ff <= row_wdata;
      end
      if (s1_go) begin
         rsp_rc_ff    <= rc;
         rsp_rdata_ff <= rdata;
         rsp_rsize_ff <= rsize;
         rsp_fire_ff  <= fire;
         rsp_nq_ff    <= nq;
         rsp_irq_ff   <= isr_next;
      end
   end

   // the RAM always reads the row of the selection that the next request sees
   assign sel_in = s1_go ? sel_next : sel_ff;
   assign ram_we = s1_go && row_we;

   vlrb_ram #(
      .WIDTH (RW),
      .DEPTH (MAX_QUEUES)
   ) u_rows (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (sel_ff),
      .wr_data (row_wdata),
      .rd_addr (sel_in),
      .rd_data (ram_rd)
   );

   always_comb begin
      if (fwd_ff) begin
         cur_row = fwd_row_ff;
      end else if (row_valid_ff[sel_ff]) begin
         cur_row = ram_rd;
      end else begin
         cur_row = '0;
      end
   end

   assign live     = (LW'(queue_count_ff) < LW'(MAX_QUEUES)) ? LW'(queue_count_ff)
                                                             : LW'(MAX_QUEUES);
   assign queue_ok = LW'(sel_ff) < live;
   assign d16      = s1_ff.write_data[15:0];
   assign d16_ok   = d16 < 16'(live);

   // ring end = align(base + 18n + 6) + 8n + 6; base is page aligned, so the
   // alignment only touches the queue-size part
   assign n_ext      = RING_SPAN_W'(cur_row.entries);
   assign desc_avail = (n_ext << 4) + (n_ext << 1) + RING_SPAN_W'(AVAIL_TAIL + PAGE_MASK);
   assign used_off   = desc_avail & ~RING_SPAN_W'(PAGE_MASK);
   assign ring_span  = used_off + (n_ext << 3) + RING_SPAN_W'(USED_TAIL);
   assign ring_last  = (RING_END_W'(s1_ff.write_data) << PAGE_SHIFT)
                       + RING_END_W'(ring_span);
   assign ring_fits  = ring_last <= RING_END_W'(guest_memory_ff);

   always_comb begin
      rc              = RC_UNSUPPORTED;
      rdata           = '0;
      rsize           = SIZE_NONE;
      fire            = 1'b0;
      nq              = '0;
      row_we          = 1'b0;
      row_wdata       = cur_row;
      sel_next        = sel_ff;
      dev_status_next = dev_status_ff;
      isr_next        = isr_ff;
      unique case (func_type'(s1_ff.func))
         FUNC_READ: begin
            unique case (s1_ff.port)
               PORT_DEV_FEATURES: begin
                  rc    = RC_OK;
                  rdata = host_features_ff;
                  rsize = SIZE_WORD;
               end
               PORT_QUEUE_PFN: begin
                  if (queue_ok) begin
                     rc    = RC_OK;
                     rdata = cur_row.page;
                     rsize = SIZE_WORD;
                  end
               end
               PORT_QUEUE_SIZE: begin
                  if (queue_ok) begin
                     rc    = RC_OK;
                     rdata = 32'(cur_row.entries);
                     rsize = SIZE_HALF;
                  end
               end
               PORT_DEVICE_STATUS: begin
                  rc    = RC_OK;
                  rdata = 32'(dev_status_ff);
                  rsize = SIZE_BYTE;
               end
               PORT_ISR_STATUS: begin
                  rc       = RC_OK;
                  rdata    = 32'(isr_ff);
                  rsize    = SIZE_BYTE;
                  isr_next = 1'b0;
               end
               default: begin
                  if (s1_ff.port >= PORT_DEVICE_BASE) rc = RC_DEVICE;
               end
            endcase
         end
         FUNC_WRITE: begin
            unique case (s1_ff.port)
               PORT_DRV_FEATURES: begin
                  if (s1_ff.xfer_bytes != SIZE_WORD) rc = RC_BAD_SIZE;
                  else rc = (s1_ff.write_data == host_features_ff) ? RC_OK : RC_MISMATCH;
               end
               PORT_DEVICE_STATUS: begin
                  if (s1_ff.xfer_bytes != SIZE_BYTE) begin
                     rc = RC_BAD_SIZE;
                  end else begin
                     rc              = RC_OK;
                     dev_status_next = s1_ff.write_data[7:0];
                  end
               end
               PORT_QUEUE_PFN: begin
                  if (s1_ff.xfer_bytes != SIZE_WORD) begin
                     rc = RC_BAD_SIZE;
                  end else if (queue_ok) begin
                     row_we = 1'b1;
                     if (ring_fits) begin
                        rc             = RC_OK;
                        row_wdata.page = s1_ff.write_data;
                     end else begin
                        // ring does not fit: the queue is torn down
                        rc        = RC_RANGE;
                        row_wdata = '0;
                     end
                  end
               end
               PORT_QUEUE_SIZE: begin
                  if (s1_ff.xfer_bytes != SIZE_HALF) begin
                     rc = RC_BAD_SIZE;
                  end else if (queue_ok) begin
                     rc                = RC_OK;
                     row_we            = 1'b1;
                     row_wdata.entries = d16;
                  end
               end
               PORT_QUEUE_SELECT: begin
                  if (s1_ff.xfer_bytes != SIZE_HALF) begin
                     rc = RC_BAD_SIZE;
                  end else if (d16_ok) begin
                     rc       = RC_OK;
                     sel_next = d16[QW-1:0];
                  end
               end
               PORT_QUEUE_NOTIFY: begin
                  if (s1_ff.xfer_bytes != SIZE_HALF) begin
                     rc = RC_BAD_SIZE;
                  end else if (d16_ok) begin
                     rc   = RC_OK;
                     fire = 1'b1;
                     nq   = d16[2:0];
                  end
               end
               default: begin
                  if (s1_ff.port >= PORT_DEVICE_BASE) rc = RC_DEVICE;
               end
            endcase
         end
         FUNC_USED: begin
            rc       = RC_OK;
            isr_next = 1'b1;
         end
         default: ;
      endcase
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.result_code  = rsp_rc_ff;
   assign rsp_chan.read_data    = rsp_rdata_ff;
   assign rsp_chan.read_size    = rsp_rsize_ff;
   assign rsp_chan.notify_fire  = rsp_fire_ff;
   assign rsp_chan.notify_queue = rsp_nq_ff;
   assign rsp_chan.irq_pending  = rsp_irq_ff;

   a_sel_in_range: assert property (@(posedge clock) disable iff (reset)
      (32'(sel_ff) < 32'(MAX_QUEUES)))
      else $error("queue selection out of range");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (s1_valid_ff && rsp_valid_ff))
      else $error("request stalled with a free stage");

   a_used_irq: assert property (@(posedge clock) disable iff (reset)
      (s1_go && s1_ff.func == FUNC_USED) |=> (rsp_chan.valid && rsp_chan.irq_pending))
      else $error("queue used event did not raise the interrupt");

   a_notify_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.notify_fire) |-> (rsp_chan.result_code == RC_OK
         && rsp_chan.read_size == SIZE_NONE))
      else $error("notify reported with a failing status");

   a_fwd_after_write: assert property (@(posedge clock) disable iff (reset)
      ram_we |=> (fwd_ff && row_valid_ff[$past(sel_ff)]))
      else $error("row write not forwarded");

endmodule

// File: hw/rtl/vlrb_ram.sv
module vlrb_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 8
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: verif/tb_virtio_legacy_register_block.sv
`timescale 1ns / 100ps

module tb_virtio_legacy_register_block;
   import vlrb_pkg::*;

   localparam int QUEUE_SLOTS = 8;
   localparam int RANDOM_PHASES = 6;
   localparam int RANDOM_PER_PHASE = 305;
   localparam logic [1:0] FUNC_SPARE = 2'd3;

   typedef enum {RX_OPEN, RX_COIN, RX_QUARTER, RX_SPARSE} rx_style_type;

   typedef struct packed {
      rc_type      code;
      logic [31:0] rdata;
      logic [2:0]  rsize;
      logic        fire;
      logic [2:0]  nq;
      logic        irq;
   } reg_answer_type;

   typedef struct {
      bit             is_cfg;
      csr_index_type  cfg_sel;
      logic [40:0]    cfg_val;
      req_type        req;
      bit             typed;
      reg_answer_type want;
   } script_row_type;

   logic clock = 1'b0;
   logic reset;

   vlrb_req_if req_chan ();
   vlrb_rsp_if rsp_chan ();
   vlrb_csr_if csr_chan ();

   virtio_legacy_register_block #(.MAX_QUEUES(QUEUE_SLOTS)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always #6 clock = ~clock;

   // shadow of the register block
   logic [31:0] cfg_features;
   logic [3:0]  cfg_queues;
   logic [40:0] cfg_mem;
   logic [31:0] pfn_shadow [QUEUE_SLOTS];
   logic [15:0] qsize_shadow [QUEUE_SLOTS];
   logic [15:0] sel_shadow;
   logic [7:0]  status_shadow;
   logic [7:0]  isr_shadow;

   reg_answer_type awaited_answers[$];
   script_row_type script[$];

   int unsigned mismatches = 0;
   int unsigned requests_sent = 0;
   int unsigned settings_written = 0;
   int unsigned answers_checked = 0;
   int unsigned range_rejects = 0;
   int unsigned notifies = 0;
   int burst_left = 0;

   function automatic req_type acc(logic [1:0] f, logic [7:0] p, logic [2:0] s,
                                   logic [31:0] d);
      req_type r;
      r.func = f;
      r.port = p;
      r.xfer_bytes = s;
      r.write_data = d;
      return r;
   endfunction

   function automatic reg_answer_type ans(rc_type c, logic [31:0] d, logic [2:0] s,
                                          logic fire, logic [2:0] q, logic irq);
      reg_answer_type a;
      a.code = c;
      a.rdata = d;
      a.rsize = s;
      a.fire = fire;
      a.nq = q;
      a.irq = irq;
      return a;
   endfunction

   function automatic void add_cfg(csr_index_type sel, logic [40:0] val);
      script_row_type row;
      row.is_cfg = 1'b1;
      row.cfg_sel = sel;
      row.cfg_val = val;
      row.req = '0;
      row.typed = 1'b0;
      row.want = '0;
      script.push_back(row);
   endfunction

   function automatic void add_req(bit typed, req_type r, reg_answer_type want);
      script_row_type row;
      row.is_cfg = 1'b0;
      row.cfg_sel = CSR_HOST_FEATURES;
      row.cfg_val = '0;
      row.req = r;
      row.typed = typed;
      row.want = want;
      script.push_back(row);
   endfunction

   // Applies one request to the shadow state and returns the answer it must produce.
   function automatic reg_answer_type bus_access_answer(req_type r);
      reg_answer_type a;
      logic [31:0] live;
      logic [15:0] d16;
      logic [2:0]  q;
      logic        qv;
      logic [63:0] n64;
      logic [63:0] used_at;
      logic [63:0] ring_end;
      a = '0;
      a.code = RC_UNSUPPORTED;
      live = (cfg_queues < QUEUE_SLOTS) ? 32'(cfg_queues) : 32'(QUEUE_SLOTS);
      qv = 32'(sel_shadow) < live;
      q = sel_shadow[2:0];
      d16 = r.write_data[15:0];
      case (r.func)
         FUNC_READ: begin
            case (r.port)
               PORT_DEV_FEATURES: begin
                  a.code = RC_OK; a.rdata = cfg_features; a.rsize = SIZE_WORD;
               end
               PORT_QUEUE_PFN: if (qv) begin
                  a.code = RC_OK; a.rdata = pfn_shadow[q]; a.rsize = SIZE_WORD;
               end
               PORT_QUEUE_SIZE: if (qv) begin
                  a.code = RC_OK; a.rdata = {16'h0, qsize_shadow[q]}; a.rsize = SIZE_HALF;
               end
               PORT_DEVICE_STATUS: begin
                  a.code = RC_OK; a.rdata = {24'h0, status_shadow}; a.rsize = SIZE_BYTE;
               end
               PORT_ISR_STATUS: begin
                  a.code = RC_OK; a.rdata = {24'h0, isr_shadow}; a.rsize = SIZE_BYTE;
                  isr_shadow = 8'h0;
               end
               default: if (r.port >= PORT_DEVICE_BASE) a.code = RC_DEVICE;
            endcase
         end
         FUNC_WRITE: begin
            case (r.port)
               PORT_DRV_FEATURES: begin
                  if (r.xfer_bytes != SIZE_WORD) a.code = RC_BAD_SIZE;
                  else a.code = (r.write_data == cfg_features) ? RC_OK : RC_MISMATCH;
               end
               PORT_DEVICE_STATUS: begin
                  if (r.xfer_bytes != SIZE_BYTE) a.code = RC_BAD_SIZE;
                  else begin
                     status_shadow = r.write_data[7:0];
                     a.code = RC_OK;
                  end
               end
               PORT_QUEUE_PFN: begin
                  if (r.xfer_bytes != SIZE_WORD) a.code = RC_BAD_SIZE;
                  else if (qv) begin
                     // descriptors + avail ring take 18 bytes per entry, used ring 8
                     n64 = 64'(qsize_shadow[q]);
                     used_at = (64'(r.write_data) << PAGE_SHIFT) + 18 * n64 + AVAIL_TAIL
                               + PAGE_MASK;
                     used_at = used_at & ~64'(PAGE_MASK);
                     ring_end = used_at + 8 * n64 + USED_TAIL;
                     if (ring_end > 64'(cfg_mem)) begin
                        pfn_shadow[q] = '0;
                        qsize_shadow[q] = '0;
                        a.code = RC_RANGE;
                     end else begin
                        pfn_shadow[q] = r.write_data;
                        a.code = RC_OK;
                     end
                  end
               end
               PORT_QUEUE_SIZE: begin
                  if (r.xfer_bytes != SIZE_HALF) a.code = RC_BAD_SIZE;
                  else if (qv) begin
                     qsize_shadow[q] = d16;
                     a.code = RC_OK;
                  end
               end
               PORT_QUEUE_SELECT: begin
                  if (r.xfer_bytes != SIZE_HALF) a.code = RC_BAD_SIZE;
                  else if (32'(d16) < live) begin
                     sel_shadow = d16;
                     a.code = RC_OK;
                  end
               end
               PORT_QUEUE_NOTIFY: begin
                  if (r.xfer_bytes != SIZE_HALF) a.code = RC_BAD_SIZE;
                  else if (32'(d16) < live) begin
                     a.code = RC_OK; a.fire = 1'b1; a.nq = d16[2:0];
                  end
               end
               default: if (r.port >= PORT_DEVICE_BASE) a.code = RC_DEVICE;
            endcase
         end
         FUNC_USED: begin
            isr_shadow = isr_shadow | 8'h1;
            a.code = RC_OK;
         end
         default: ;
      endcase
      a.irq = isr_shadow != 8'h0;
      return a;
   endfunction

   function automatic logic [2:0] pick_size(logic [2:0] right);
      return ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7)) : right;
   endfunction

   function automatic logic [15:0] pick_queue_arg();
      return ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 9));
   endfunction

   // Mostly well-formed register traffic of every kind, with the ring base often aimed at the memory top.
   function automatic req_type random_access();
      int pick;
      logic [15:0] low;
      logic [31:0] pfn;
      logic [7:0]  rd_port;
      pick = $urandom_range(0, 99);
      if (pick < 12)
         return acc(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                    3'($urandom_range(0, 7)), $urandom);
      if (pick < 24)
         return acc(FUNC_WRITE, PORT_QUEUE_SELECT, pick_size(SIZE_HALF),
                    {16'($urandom), pick_queue_arg()});
      if (pick < 34) begin
         case ($urandom_range(0, 9))
            0: low = 16'hFFFF;
            1: low = 16'($urandom);
            default: low = 16'($urandom_range(0, 600));
         endcase
         return acc(FUNC_WRITE, PORT_QUEUE_SIZE, pick_size(SIZE_HALF), {16'($urandom), low});
      end
      if (pick < 48) begin
         case ($urandom_range(0, 4))
            0: pfn = $urandom;
            1: pfn = 32'($urandom_range(0, 15));
            default: pfn = 32'(cfg_mem >> PAGE_SHIFT) - 32'($urandom_range(0, 3));
         endcase
         return acc(FUNC_WRITE, PORT_QUEUE_PFN, pick_size(SIZE_WORD), pfn);
      end
      if (pick < 58)
         return acc(FUNC_WRITE, PORT_QUEUE_NOTIFY, pick_size(SIZE_HALF),
                    {16'($urandom), pick_queue_arg()});
      if (pick < 64) begin
         case ($urandom_range(0, 3))
            0: pfn = $urandom;
            1: pfn = cfg_features ^ (32'h1 << $urandom_range(0, 31));
            default: pfn = cfg_features;
         endcase
         return acc(FUNC_WRITE, PORT_DRV_FEATURES, pick_size(SIZE_WORD), pfn);
      end
      if (pick < 70)
         return acc(FUNC_WRITE, PORT_DEVICE_STATUS, pick_size(SIZE_BYTE), $urandom);
      if (pick < 86) begin
         case ($urandom_range(0, 5))
            0: rd_port = PORT_DEV_FEATURES;
            1: rd_port = PORT_QUEUE_PFN;
            2: rd_port = PORT_QUEUE_SIZE;
            3: rd_port = PORT_DEVICE_STATUS;
            4: rd_port = PORT_ISR_STATUS;
            default: rd_port = PORT_QUEUE_SELECT;
         endcase
         return acc(FUNC_READ, rd_port, 3'($urandom_range(0, 7)), $urandom);
      end
      return acc(FUNC_USED, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)), $urandom);
   endfunction

   task automatic issue(input req_type r, input bit typed, input reg_answer_type typed_want);
      reg_answer_type a;
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 250)
                                                  : $urandom_range(1, 24);
      end
      burst_left--;
      req_chan.valid <= 1'b1;
      req_chan.func <= r.func;
      req_chan.port <= r.port;
      req_chan.xfer_bytes <= r.xfer_bytes;
      req_chan.write_data <= r.write_data;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      a = bus_access_answer(r);
      awaited_answers.push_back(typed ? typed_want : a);
      requests_sent++;
   endtask

   // register writes only go out once the block has drained
   task automatic program_reg(input csr_index_type sel, input logic [40:0] val);
      req_chan.valid <= 1'b0;
      while (awaited_answers.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= sel;
      csr_chan.data <= val;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      csr_chan.valid <= 1'b0;
      case (sel)
         CSR_HOST_FEATURES: cfg_features = val[31:0];
         CSR_QUEUE_COUNT:   cfg_queues = val[3:0];
         CSR_GUEST_MEMORY:  cfg_mem = val;
         default: ;
      endcase
      settings_written++;
   endtask

   function automatic void note_field(string what, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
         mismatches++;
      end
   endfunction

   initial begin
      #5_000_000;
      $display("virtio_legacy_register_block regression: fail");
      $finish;
   end

   initial begin : answer_sink
      reg_answer_type want;
      rx_style_type style;
      int style_left;
      int hold_left;
      int unsigned beat;
      style = RX_OPEN;
      style_left = 0;
      hold_left = 0;
      beat = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (awaited_answers.size() == 0) begin
               $display("%0t: answer with nothing outstanding, expected none, actual code 0x%0h",
                        $time, rsp_chan.result_code);
               mismatches++;
            end else begin
               want = awaited_answers.pop_front();
               note_field("result_code", want.code, rsp_chan.result_code);
               note_field("read_data", want.rdata, rsp_chan.read_data);
               note_field("read_size", want.rsize, rsp_chan.read_size);
               note_field("notify_fire", want.fire, rsp_chan.notify_fire);
               note_field("notify_queue", want.nq, rsp_chan.notify_queue);
               note_field("irq_pending", want.irq, rsp_chan.irq_pending);
               answers_checked++;
               if (want.code == RC_RANGE) range_rejects++;
               if (want.fire) notifies++;
               // long back-pressure so both pipeline stages fill
               if (answers_checked == 400 || answers_checked == 1400) hold_left = 250;
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            if (style_left == 0) begin
               style = rx_style_type'($urandom_range(0, 3));
               style_left = $urandom_range(20, 150);
            end
            style_left--;
            case (style)
               RX_OPEN:    rsp_chan.ready <= 1'b1;
               RX_COIN:    rsp_chan.ready <= 1'($urandom_range(0, 1));
               RX_QUARTER: rsp_chan.ready <= (beat % 4) == 0;
               default:    rsp_chan.ready <= $urandom_range(0, 7) != 0;
            endcase
         end
         beat++;
      end
   end

   initial begin : request_source
      int phase;
      logic [31:0] feat;
      logic [3:0]  qcount;
      logic [40:0] mem;
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.func <= FUNC_READ;
      req_chan.port <= PORT_DEV_FEATURES;
      req_chan.xfer_bytes <= SIZE_NONE;
      req_chan.write_data <= '0;
      csr_chan.valid <= 1'b0;
      csr_chan.index <= CSR_HOST_FEATURES;
      csr_chan.data <= '0;

      cfg_features = '0;
      cfg_queues = 4'd1;
      cfg_mem = '0;
      for (int i = 0; i < QUEUE_SLOTS; i++) begin
         pfn_shadow[i] = '0;
         qsize_shadow[i] = '0;
      end
      sel_shadow = '0;
      status_shadow = '0;
      isr_shadow = '0;

      // reset values, no guest memory
      add_req(1, acc(FUNC_READ, PORT_DEV_FEATURES, SIZE_WORD, 32'h0),
              ans(RC_OK, 32'h0, SIZE_WORD, 1'b0, 3'd0, 1'b0));
      add_req(1, acc(FUNC_READ, PORT_QUEUE_PFN, SIZE_NONE, 32'h0),
              ans(RC_OK, 32'h0, SIZE_WORD, 1'b0, 3'd0, 1'b0));
      add_req(1, acc(FUNC_WRITE, PORT_DRV_FEATURES, SIZE_WORD, 32'h0),
              ans(RC_OK, 32'h0, SIZE_NONE, 1'b0, 3'd0, 1'b0));
      add_req(1, acc(FUNC_WRITE, PORT_QUEUE_PFN, SIZE_WORD, 32'h0),
              ans(RC_RANGE, 32'h0, SIZE_NONE, 1'b0, 3'd0, 1'b0));
      // widest settings
      add_cfg(CSR_HOST_FEATURES, 41'hFFFF_FFFF);
      add_cfg(CSR_QUEUE_COUNT, 41'd8);
      add_cfg(CSR_GUEST_MEMORY, 41'h100_0000_0000);
      add_req(1, acc(FUNC_WRITE, PORT_DRV_FEATURES, SIZE_WORD, 32'hFFFF_FFFF),
              ans(RC_OK, 32'h0, SIZE_NONE, 1'b0, 3'd0, 1'b0));
      add_req(1, acc(FUNC_WRITE, PORT_DRV_FEATURES, SIZE_WORD, 32'h7FFF_FFFF),
              ans(RC_MISMATCH, 32'h0, SIZE_NONE, 1'b0, 3'd0, 1'b0));
      add_req(1, acc(FUNC_WRITE, PORT_QUEUE_SELECT, SIZE_HALF, 32'hFFFF_0007),
              ans(RC_OK, 32'h0, SIZE_NONE, 1'b0, 3'd0, 1'b0));
      add_req(1, acc(FUNC_WRITE, PORT_QUEUE_SIZE, SIZE_HALF, 32'h0000_FFFF),
              ans(RC_OK, 32'h0, SIZE_NONE, 1'b0, 3'd0, 1'b0));
      add_req(1, acc(FUNC_WRITE, PORT_QUEUE_PFN, SIZE_WORD, 32'hFFFF_FFFF),
              ans(RC_RANGE, 32'h0, SIZE_NONE, 1'b0, 3'd0, 1'b0));
      add_req(0, acc(FUNC_READ, PORT_QUEUE_SIZE, SIZE_HALF, 32'h0), '0);
      // one-entry ring just past and just inside the top of memory
      add_req(0, acc(FUNC_WRITE, PORT_QUEUE_SIZE, SIZE_HALF, 32'h1), '0);
      add_req(0, acc(FUNC_WRITE, PORT_QUEUE_PFN, SIZE_WORD, 32'h0FFF_FFFF), '0);
      add_req(0, acc(FUNC_WRITE, PORT_QUEUE_SIZE, SIZE_HALF, 32'h1), '0);
      add_req(0, acc(FUNC_WRITE, PORT_QUEUE_PFN, SIZE_WORD, 32'h0FFF_FFFE), '0);
      add_req(0, acc(FUNC_READ, PORT_QUEUE_PFN, SIZE_WORD, 32'h0), '0);
      add_req(1, acc(FUNC_WRITE, PORT_QUEUE_SELECT, SIZE_HALF, 32'h8),
              ans(RC_UNSUPPORTED, 32'h0, SIZE_NONE, 1'b0, 3'd0, 1'b0));
      add_req(1, acc(FUNC_WRITE, PORT_QUEUE_NOTIFY, SIZE_HALF, 32'h7),
              ans(RC_OK, 32'h0, SIZE_NONE, 1'b1, 3'd7, 1'b0));
      add_req(1, acc(FUNC_WRITE, PORT_QUEUE_NOTIFY, SIZE_WORD, 32'h7),
              ans(RC_BAD_SIZE, 32'h0, SIZE_NONE, 1'b0, 3'd0, 1'b0));
      add_req(0, acc(FUNC_WRITE, PORT_DEVICE_STATUS, SIZE_BYTE, 32'hFFFF_FFFF), '0);
      add_req(0, acc(FUNC_READ, PORT_DEVICE_STATUS, SIZE_WORD, 32'h0), '0);
      add_req(1, acc(FUNC_USED, 8'hFF, 3'd7, 32'hFFFF_FFFF),
              ans(RC_OK, 32'h0, SIZE_NONE, 1'b0, 3'd0, 1'b1));
      add_req(1, acc(FUNC_READ, PORT_ISR_STATUS, SIZE_BYTE, 32'h0),
              ans(RC_OK, 32'h1, SIZE_BYTE, 1'b0, 3'd0, 1'b0));
      add_req(1, acc(FUNC_READ, PORT_DEVICE_BASE, SIZE_WORD, 32'h0),
              ans(RC_DEVICE, 32'h0, SIZE_NONE, 1'b0, 3'd0, 1'b0));
      add_req(1, acc(FUNC_WRITE, 8'hFF, SIZE_BYTE, 32'h0),
              ans(RC_DEVICE, 32'h0, SIZE_NONE, 1'b0, 3'd0, 1'b0));
      add_req(1, acc(FUNC_READ, PORT_DRV_FEATURES, SIZE_WORD, 32'h0),
              ans(RC_UNSUPPORTED, 32'h0, SIZE_NONE, 1'b0, 3'd0, 1'b0));
      add_req(1, acc(FUNC_SPARE, PORT_DEV_FEATURES, SIZE_WORD, 32'h0),
              ans(RC_UNSUPPORTED, 32'h0, SIZE_NONE, 1'b0, 3'd0, 1'b0));
      // shrinking the queue count strands selection 7
      add_cfg(CSR_QUEUE_COUNT, 41'd1);
      add_req(1, acc(FUNC_READ, PORT_QUEUE_PFN, SIZE_WORD, 32'h0),
              ans(RC_UNSUPPORTED, 32'h0, SIZE_NONE, 1'b0, 3'd0, 1'b0));
      add_req(1, acc(FUNC_WRITE, PORT_QUEUE_SIZE, SIZE_HALF, 32'h5),
              ans(RC_UNSUPPORTED, 32'h0, SIZE_NONE, 1'b0, 3'd0, 1'b0));
      add_req(1, acc(FUNC_WRITE, PORT_QUEUE_SELECT, SIZE_BYTE, 32'h0),
              ans(RC_BAD_SIZE, 32'h0, SIZE_NONE, 1'b0, 3'd0, 1'b0));
      add_req(1, acc(FUNC_WRITE, PORT_QUEUE_SELECT, SIZE_HALF, 32'h0),
              ans(RC_OK, 32'h0, SIZE_NONE, 1'b0, 3'd0, 1'b0));

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         if (script[i].is_cfg) program_reg(script[i].cfg_sel, script[i].cfg_val);
         else issue(script[i].req, script[i].typed, script[i].want);
      end

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: begin
               feat = $urandom; qcount = 4'd8; mem = 41'h100_0000_0000;
            end
            1: begin
               feat = 32'h0; qcount = 4'd1; mem = '0;
            end
            2: begin
               feat = 32'hFFFF_FFFF; qcount = 4'($urandom_range(1, 8));
               mem = 41'({8'($urandom_range(0, 255)), 32'($urandom)});
            end
            default: begin
               feat = $urandom;
               qcount = (phase == 3) ? 4'd8 : 4'($urandom_range(1, 8));
               mem = (41'($urandom_range(1, 4096)) << PAGE_SHIFT)
                     + 41'($urandom_range(0, PAGE_MASK));
            end
         endcase
         program_reg(CSR_HOST_FEATURES, 41'(feat));
         program_reg(CSR_QUEUE_COUNT, 41'(qcount));
         program_reg(CSR_GUEST_MEMORY, mem);
         repeat (RANDOM_PER_PHASE) issue(random_access(), 1'b0, '0);
      end

      req_chan.valid <= 1'b0;
      while (awaited_answers.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Sent %0d requests under %0d register writes; %0d answers compared.",
               requests_sent, settings_written, answers_checked);
      $display("Seen: %0d rings rejected as out of range, %0d queue notifies.",
               range_rejects, notifies);
      if (mismatches == 0) begin
         $display("virtio_legacy_register_block regression: pass");
      end else begin
         $display("virtio_legacy_register_block regression: fail");
      end
      $finish;
   end

endmodule
